@@ src/khss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// khss_pkg
// Types, constants and arithmetic helpers shared by the key hash server
// selector modules.
// ----------------------------------------------------------------------------
package khss_pkg;

	// Hash arithmetic
	localparam int unsigned HASH_W   = 17;
	localparam int unsigned ACC_W    = 22;  // width of hash*31 + byte
	localparam int unsigned HASH_MOD = 100000;
	localparam int unsigned RED_STEPS = 5;  // 2^5 covers a quotient up to 31

	// Server slots
	localparam int unsigned MASK_BITS = 4;
	localparam int unsigned SLOT_W    = 2;
	localparam int unsigned CNT_W     = 3;
	localparam int unsigned PORT_W    = 16;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_HEALTHY_MASK = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_PORT    = 4'd1;
	localparam logic [MASK_BITS-1:0] HEALTHY_MASK_RST = 4'd3;
	localparam logic [PORT_W-1:0]    BASE_PORT_RST    = 16'd5001;

	typedef struct packed {
		logic [6:0] key_byte;
		logic       is_last;
		logic       is_empty;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] server_slot;
		logic [PORT_W-1:0] server_port;
		logic [HASH_W-1:0] key_hash;
		logic              unrouted;
	} out_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;  // take an input beat, form hash*31 + byte
		logic reduce;   // fold the product back below the modulus
		logic emit;     // load the result register, clear the hash
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_last;
		logic is_empty;
	} dp_stat_t;

	// Form hash*31 + byte as hash*32 - hash + byte
	function automatic logic [ACC_W-1:0] hash_muladd(
		input logic [HASH_W-1:0] h,
		input logic [6:0]        b
	);
		logic [ACC_W-1:0] h_ext;
		h_ext = {{(ACC_W-HASH_W){1'b0}}, h};
		return (h_ext << 5) - h_ext + {{(ACC_W-7){1'b0}}, b};
	endfunction

	// Reduce a value below 32*HASH_MOD by binary weighted subtraction
	function automatic logic [HASH_W-1:0] hash_reduce(input logic [ACC_W-1:0] t);
		logic [ACC_W-1:0] r;
		logic [ACC_W-1:0] m;
		r = t;
		for (int k = RED_STEPS - 1; k >= 0; k--) begin
			m = ACC_W'(HASH_MOD) << k;
			if (r >= m) begin
				r = r - m;
			end
		end
		return r[HASH_W-1:0];
	endfunction

	// Remainder modulo 3: 4 is 1 mod 3, so sum the base-4 digits twice
	function automatic logic [1:0] mod3(input logic [HASH_W-1:0] h);
		logic [HASH_W:0] hx;
		logic [4:0]      s1;
		logic [2:0]      s2;
		logic [1:0]      r;
		hx = {1'b0, h};
		s1 = '0;
		for (int d = 0; d < (HASH_W + 1) / 2; d++) begin
			s1 = s1 + {3'b000, hx[2*d +: 2]};
		end
		s2 = {1'b0, s1[1:0]} + {1'b0, s1[3:2]} + {2'b00, s1[4]};
		case (s2)
			3'd0, 3'd3, 3'd6: r = 2'd0;
			3'd1, 3'd4, 3'd7: r = 2'd1;
			3'd2, 3'd5:       r = 2'd2;
			default:          r = 2'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/khss_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// khss_ctrl
// Sequencer for the server selector: takes input beats, steps the hash
// update and the slot pick, and owns the result valid flag.
// ----------------------------------------------------------------------------
module khss_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire khss_pkg::dp_stat_t stat,
	output khss_pkg::dp_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RED  = 2'd1;
	localparam logic [1:0] S_SEL  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       room;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign room      = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Drive datapath commands
	always_comb begin
		cmd.load_in = accept;
		cmd.reduce  = (state_q == S_RED);
		cmd.emit    = (state_q == S_SEL) && room;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_RED;
				end
			end
			S_RED: begin
				// a last byte or an empty marker goes on to the pick
				state_d = (stat.is_last || stat.is_empty) ? S_SEL : S_IDLE;
			end
			S_SEL: begin
				if (room) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken beat");

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_RED || state_q == S_SEL))
		else $error("accepted beat did not start work");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted result not shown as valid");

endmodule
`default_nettype wire

@@ src/khss_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// khss_dp
// Datapath for the server selector: running hash, configuration registers,
// healthy slot count and pick, and the result register.
// ----------------------------------------------------------------------------
module khss_dp #(
	parameter int unsigned NSLOT = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire khss_pkg::in_item_t                  in_data,
	input  wire logic                                cfg_we,
	input  wire logic [khss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [khss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire khss_pkg::dp_cmd_t                   cmd,
	output khss_pkg::dp_stat_t                       stat,
	output khss_pkg::out_item_t                      out_data
);

	logic [khss_pkg::HASH_W-1:0]    running_hash_q;
	logic [khss_pkg::ACC_W-1:0]     acc_q;
	logic                           last_q;
	logic                           empty_q;
	logic [khss_pkg::MASK_BITS-1:0] healthy_mask_q;
	logic [khss_pkg::PORT_W-1:0]    base_port_q;
	khss_pkg::out_item_t            out_q;

	logic [khss_pkg::MASK_BITS-1:0] slot_en;
	logic [khss_pkg::MASK_BITS-1:0] mask_eff;
	logic [khss_pkg::CNT_W-1:0]     healthy_cnt;
	logic [khss_pkg::CNT_W-1:0]     pick;
	logic [khss_pkg::CNT_W-1:0]     seen;
	logic [khss_pkg::SLOT_W-1:0]    slot;
	logic                           found;
	khss_pkg::out_item_t            result;

	assign stat.is_last  = last_q;
	assign stat.is_empty = empty_q;
	assign out_data      = out_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			healthy_mask_q <= khss_pkg::HEALTHY_MASK_RST;
			base_port_q    <= khss_pkg::BASE_PORT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				khss_pkg::REG_HEALTHY_MASK:
					healthy_mask_q <= cfg_wdata[khss_pkg::MASK_BITS-1:0];
				khss_pkg::REG_BASE_PORT:
					base_port_q <= cfg_wdata[khss_pkg::PORT_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the running hash: multiply-add, then reduce, clear on a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_hash_q <= '0;
		end else if (cmd.emit) begin
			running_hash_q <= '0;
		end else if (cmd.reduce) begin
			running_hash_q <= khss_pkg::hash_reduce(acc_q);
		end
	end

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			acc_q   <= khss_pkg::hash_muladd(running_hash_q, in_data.key_byte);
			last_q  <= in_data.is_last;
			empty_q <= in_data.is_empty;
		end
	end

	// Mask off slots that do not exist
	always_comb begin
		for (int i = 0; i < khss_pkg::MASK_BITS; i++) begin
			slot_en[i] = (i < NSLOT);
		end
		mask_eff = healthy_mask_q & slot_en;
	end

	// Count healthy slots and reduce the hash by that count
	always_comb begin
		healthy_cnt = '0;
		for (int i = 0; i < khss_pkg::MASK_BITS; i++) begin
			healthy_cnt = healthy_cnt + {{(khss_pkg::CNT_W-1){1'b0}}, mask_eff[i]};
		end
		case (healthy_cnt)
			3'd2:    pick = {2'b00, running_hash_q[0]};
			3'd3:    pick = {1'b0, khss_pkg::mod3(running_hash_q)};
			3'd4:    pick = {1'b0, running_hash_q[1:0]};
			default: pick = '0;
		endcase
	end

	// Find the pick-th healthy slot in slot order
	always_comb begin
		seen  = '0;
		slot  = '0;
		found = 1'b0;
		for (int i = 0; i < khss_pkg::MASK_BITS; i++) begin
			if (mask_eff[i]) begin
				if (!found && seen == pick) begin
					slot  = khss_pkg::SLOT_W'(i);
					found = 1'b1;
				end
				seen = seen + {{(khss_pkg::CNT_W-1){1'b0}}, 1'b1};
			end
		end
	end

	// Build the result beat
	always_comb begin
		if (empty_q || healthy_cnt == '0) begin
			result = '0;
			result.unrouted = 1'b1;
		end else begin
			result.server_slot = slot;
			result.server_port = base_port_q
				+ {{(khss_pkg::PORT_W-khss_pkg::SLOT_W){1'b0}}, slot};
			result.key_hash    = running_hash_q;
			result.unrouted    = 1'b0;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= result;
		end
	end

	a_emit_clears_hash: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> running_hash_q == '0)
		else $error("hash not cleared after a result");

	a_reduce_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reduce |=> running_hash_q < khss_pkg::HASH_W'(khss_pkg::HASH_MOD))
		else $error("reduced hash out of range");

endmodule
`default_nettype wire

@@ src/key_hash_server_selector.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// key_hash_server_selector
// Hashes a request key one byte per beat and picks a healthy server slot.
// ----------------------------------------------------------------------------
// Middle byte: multiply-add on accept, then the modulo fold, then back to idle for the next beat.
// Last byte or empty key: result register loaded after the fold and then the slot pick,
// once the output has room; only then is the next beat taken.
// An untaken result holds the slot pick, and with it the input, until it drains.
// Reset: hash 0, healthy mask 3, base port 5001, no result pending.
// ----------------------------------------------------------------------------
module key_hash_server_selector #(
	parameter int unsigned SERVER_SLOTS = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire khss_pkg::in_item_t                in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output khss_pkg::out_item_t                    out_data,
	input  wire logic                              cfg_we,
	input  wire logic [khss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [khss_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int unsigned NSLOT = (SERVER_SLOTS < khss_pkg::MASK_BITS)
		? SERVER_SLOTS : khss_pkg::MASK_BITS;

	khss_pkg::dp_cmd_t  cmd;
	khss_pkg::dp_stat_t stat;

	khss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	khss_dp #(
		.NSLOT (NSLOT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

@@ tb/key_hash_server_selector_tb.sv @@
// ----------------------------------------------------------------------------
// key_hash_server_selector_tb
// Streams request keys byte by byte into the server selector and checks every
// route against a cycle-free predictor of the hash and the slot pick. Covers
// key extremes, empty and broken keys, every healthy mask, port wrap, unused
// register writes, long output stalls and random traffic with random idling.
// ----------------------------------------------------------------------------
module key_hash_server_selector_tb;

	localparam int unsigned SERVER_SLOTS   = 4;
	localparam int unsigned MASK_W         = 4;
	localparam int unsigned SLOT_LIMIT     = (SERVER_SLOTS < MASK_W) ? SERVER_SLOTS : MASK_W;
	localparam int unsigned HASH_MULT      = 31;
	localparam int unsigned HASH_MODULUS   = 100000;
	localparam int unsigned IDX_W          = khss_pkg::CFG_IDX_W;
	localparam int unsigned DATA_W         = khss_pkg::CFG_DATA_W;
	localparam logic [3:0]  RESET_MASK     = 4'd3;
	localparam logic [15:0] RESET_BASE     = 16'd5001;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned HOLD_OFF_LEN   = 300;
	localparam int unsigned RANDOM_PHASES  = 10;
	localparam int unsigned PHASE_ITEMS    = 130;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	khss_pkg::in_item_t   in_data;
	logic                 out_valid;
	logic                 out_ready;
	khss_pkg::out_item_t  out_data;
	logic                 cfg_we;
	logic [IDX_W-1:0]     cfg_index;
	logic [DATA_W-1:0]    cfg_wdata;

	// Predictor state and configuration copy
	int unsigned hash_acc;
	logic [MASK_W-1:0] cur_mask;
	logic [15:0] cur_base;
	khss_pkg::out_item_t pending_routes[$];
	int unsigned mismatches = 0;

	// Idling controls
	bit tx_idle_on;
	bit rx_stalls_on;
	int unsigned hold_off_req;

	key_hash_server_selector #(
		.SERVER_SLOTS(SERVER_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Fold one key byte into the running hash; return 1 when it ends a key
	function automatic logic route_beat(input khss_pkg::in_item_t beat,
		output khss_pkg::out_item_t route);
		int unsigned healthy;
		int unsigned pick;
		int unsigned slot;
		route = '0;
		if (beat.is_empty) begin
			hash_acc = 0;
			route.unrouted = 1'b1;
			return 1'b1;
		end
		hash_acc = (hash_acc * HASH_MULT + beat.key_byte) % HASH_MODULUS;
		if (!beat.is_last) begin
			return 1'b0;
		end
		healthy = 0;
		for (int i = 0; i < SLOT_LIMIT; i++) begin
			healthy += cur_mask[i];
		end
		if (healthy == 0) begin
			hash_acc = 0;
			route.unrouted = 1'b1;
			return 1'b1;
		end
		// Walk the mask to the n-th healthy slot
		pick = hash_acc % healthy;
		slot = 0;
		for (int i = 0; i < SLOT_LIMIT; i++) begin
			if (cur_mask[i]) begin
				if (pick == 0) begin
					slot = i;
					break;
				end
				pick--;
			end
		end
		route.server_slot = 2'(slot);
		route.server_port = cur_base + 16'(slot);
		route.key_hash    = 17'(hash_acc);
		hash_acc = 0;
		return 1'b1;
	endfunction

	function automatic logic [6:0] rand_byte();
		return 7'($urandom_range(0, 127));
	endfunction

	// Mostly back to back, some short gaps, a few long ones
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned key_len();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(9, 40);
		end
		return $urandom_range(1, 8);
	endfunction

	// Offer one key beat and hold it until accepted
	task automatic offer_beat(input khss_pkg::in_item_t beat);
		int unsigned idle;
		khss_pkg::out_item_t route;
		idle = tx_idle_on ? gap_len() : 0;
		@(negedge clk);
		if (idle > 0) begin
			in_valid = 1'b0;
			repeat (idle) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = beat;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (route_beat(beat, route)) begin
			pending_routes = {pending_routes, route};
		end
	endtask

	task automatic send_key(input int unsigned len);
		for (int unsigned k = 0; k < len; k++) begin
			offer_beat(khss_pkg::in_item_t'{key_byte: rand_byte(),
				is_last: (k == len - 1), is_empty: 1'b0});
		end
	endtask

	task automatic send_empty();
		offer_beat(khss_pkg::in_item_t'{key_byte: rand_byte(), is_last: 1'($urandom),
			is_empty: 1'b1});
	endtask

	// Drop valid, wait for every route, then let the pipeline go quiet
	task automatic settle_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_routes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx,
		input logic [DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		if (idx == khss_pkg::REG_HEALTHY_MASK) begin
			cur_mask = data[MASK_W-1:0];
		end else if (idx == khss_pkg::REG_BASE_PORT) begin
			cur_base = data;
		end
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Mostly whole keys, some empty markers, some keys cut short by an empty marker
	task automatic send_random_items(input int unsigned count);
		int unsigned sent;
		int unsigned len;
		int unsigned r;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				len = key_len();
				send_key(len);
				sent += len;
			end else if (r < 88) begin
				send_empty();
				sent++;
			end else begin
				len = $urandom_range(1, 5);
				for (int unsigned k = 0; k < len; k++) begin
					offer_beat(khss_pkg::in_item_t'{key_byte: rand_byte(), is_last: 1'b0,
						is_empty: 1'b0});
				end
				send_empty();
				sent += len + 1;
			end
		end
	endtask

	// Byte extremes, empty markers both ways, hash wrap, empty mid-key
	task automatic test_reset_defaults();
		offer_beat(khss_pkg::in_item_t'{key_byte: 7'h7F, is_last: 1'b0, is_empty: 1'b1});
		offer_beat(khss_pkg::in_item_t'{key_byte: 7'h00, is_last: 1'b1, is_empty: 1'b1});
		offer_beat(khss_pkg::in_item_t'{key_byte: 7'h00, is_last: 1'b1, is_empty: 1'b0});
		offer_beat(khss_pkg::in_item_t'{key_byte: 7'h7F, is_last: 1'b1, is_empty: 1'b0});
		for (int k = 0; k < 6; k++) begin
			offer_beat(khss_pkg::in_item_t'{key_byte: 7'h7F, is_last: (k == 5),
				is_empty: 1'b0});
		end
		for (int k = 0; k < 3; k++) begin
			offer_beat(khss_pkg::in_item_t'{key_byte: rand_byte(), is_last: 1'b0,
				is_empty: 1'b0});
		end
		offer_beat(khss_pkg::in_item_t'{key_byte: 7'h55, is_last: 1'b0, is_empty: 1'b1});
		offer_beat(khss_pkg::in_item_t'{key_byte: 7'h41, is_last: 1'b1, is_empty: 1'b0});
		settle_idle();
	endtask

	// Every healthy mask, port extremes and wrap, then unused register writes
	task automatic test_slot_masks();
		logic [15:0] base;
		for (int m = 0; m < 16; m++) begin
			if (m == 5) begin
				base = 16'h0000;
			end else if (m == 10) begin
				base = 16'hFFFE;
			end else if (m == 15) begin
				base = 16'hFFFF;
			end else begin
				base = 16'($urandom);
			end
			write_reg(khss_pkg::REG_HEALTHY_MASK, {12'($urandom), 4'(m)});
			write_reg(khss_pkg::REG_BASE_PORT, base);
			for (int k = 0; k < 3; k++) begin
				send_key($urandom_range(1, 4));
			end
			settle_idle();
		end
		write_reg(khss_pkg::REG_HEALTHY_MASK, {12'hFFF, 4'b1011});
		write_reg(khss_pkg::REG_BASE_PORT, 16'd7000);
		for (int idx = int'(khss_pkg::REG_BASE_PORT) + 1; idx < (1 << IDX_W); idx++) begin
			write_reg(IDX_W'(idx), (idx[0]) ? 16'hFFFF : 16'($urandom));
		end
		for (int k = 0; k < 6; k++) begin
			send_key($urandom_range(1, 5));
		end
		settle_idle();
	endtask

	// Hold off the sink for a long stretch while keys keep coming
	task automatic test_backpressure();
		write_reg(khss_pkg::REG_HEALTHY_MASK, 16'h000F);
		tx_idle_on   = 1'b0;
		hold_off_req = HOLD_OFF_LEN;
		for (int k = 0; k < 40; k++) begin
			if (k % 8 == 7) begin
				send_empty();
			end else begin
				send_key(1);
			end
		end
		tx_idle_on = 1'b1;
		settle_idle();
	endtask

	// Pause the source until every route is back, several times over
	task automatic test_drain_pause();
		for (int r = 0; r < 5; r++) begin
			send_random_items($urandom_range(5, 15));
			settle_idle();
		end
	endtask

	task automatic test_random_traffic();
		logic [3:0] mask;
		logic [15:0] base;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			mask = (p == 0) ? 4'h0 : (p == 1) ? 4'hF : 4'($urandom);
			base = (p == 2) ? 16'h0000 : (p == 4) ? 16'hFFFF : 16'($urandom);
			write_reg(khss_pkg::REG_HEALTHY_MASK, {12'($urandom), mask});
			write_reg(khss_pkg::REG_BASE_PORT, base);
			// One phase runs with no idling on either side
			tx_idle_on   = (p != 3);
			rx_stalls_on = (p != 3);
			send_random_items(PHASE_ITEMS);
			settle_idle();
		end
		tx_idle_on   = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	// Drive the sink ready with random stalls and requested hold-offs
	initial begin : route_sink
		int unsigned stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req > 0) begin
				stall_left   = hold_off_req;
				hold_off_req = 0;
			end
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
				out_ready  = 1'b0;
				stall_left = (gap_len() > 0) ? gap_len() : 0;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Compare each route beat with the oldest prediction
	always @(posedge clk) begin : route_check
		khss_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_routes.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected route, expected none, got slot=%0d port=%0d",
					$time, out_data.server_slot, out_data.server_port,
					" hash=%0d none=%0b", out_data.key_hash, out_data.unrouted);
			end else begin
				want = pending_routes.pop_front();
				if (out_data.server_slot !== want.server_slot ||
					out_data.server_port !== want.server_port ||
					out_data.key_hash !== want.key_hash ||
					out_data.unrouted !== want.unrouted) begin
					mismatches++;
					$display("%0t: route mismatch, expected slot=%0d port=%0d hash=%0d",
						$time, want.server_slot, want.server_port, want.key_hash,
						" none=%0b, got slot=%0d port=%0d hash=%0d none=%0b",
						want.unrouted, out_data.server_slot, out_data.server_port,
						out_data.key_hash, out_data.unrouted);
				end
			end
		end
	end

	// End the run when no beat moves on either side for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		tx_idle_on   = 1'b1;
		rx_stalls_on = 1'b1;
		hold_off_req = 0;
		hash_acc     = 0;
		cur_mask     = RESET_MASK;
		cur_base     = RESET_BASE;
		arst_n       = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_slot_masks();
		test_backpressure();
		test_drain_pause();
		test_random_traffic();
		settle_idle();

		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/khss_pkg.sv
src/khss_ctrl.sv
src/khss_dp.sv
src/key_hash_server_selector.sv
tb/key_hash_server_selector_tb.sv
